// ----- rtl/rpr_pkg.sv -----
package rpr_pkg;

  // Image and sample geometry
  localparam int unsigned Channels      = 4;
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned MaxSrcWidth   = 1024;
  localparam int unsigned MaxOutWidth   = MaxSrcWidth / 2;
  localparam int unsigned MaxOutHeight  = 4096;

  // Counter and field widths
  localparam int unsigned ColBits       = $clog2(MaxSrcWidth);
  localparam int unsigned RowBits       = 13;
  localparam int unsigned WidthRegBits  = 10;
  localparam int unsigned HeightRegBits = 13;
  localparam int unsigned OutColBits    = 9;
  localparam int unsigned OutRowBits    = 12;
  localparam int unsigned AddrBits      = ColBits;

  // Filter arithmetic: column sum grows by 2 bits, full 3x3 sum by 4 bits
  localparam int unsigned VsumBits      = SampleBits + 2;
  localparam int unsigned AccBits       = SampleBits + 4;

  // Stream word widths
  localparam int unsigned PixelBits     = Channels * SampleBits;
  localparam int unsigned OutFieldBits  = PixelBits + OutColBits + OutRowBits;
  localparam int unsigned OutDataBits   = ((OutFieldBits + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 13;
  localparam logic [CfgIdxBits-1:0] CFG_OUT_WIDTH  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_OUT_HEIGHT = 2'd1;

  typedef logic [Channels-1:0][SampleBits-1:0] pixel_t;

  // One entry of the line store: rows r-2 and r-1 at one column
  typedef struct packed {
    pixel_t one_back;
    pixel_t two_back;
  } line_word_t;

  // Position info for the source pixel at the head of the scan
  typedef struct packed {
    logic                  last_col;
    logic                  last_row;
    logic                  emit;
    logic [AddrBits-1:0]   addr;
    logic [OutColBits-1:0] out_col;
    logic [OutRowBits-1:0] out_row;
  } scan_info_t;

endpackage

// ----- rtl/rgba_pyramid_reduce_3x3_core.sv -----
// One level of a four-channel image pyramid. Source pixels of a 2W x 2H image
// arrive in raster order on the input stream; each output pixel is the 1-2-1 by
// 1-2-1 binomial weighted sum of source columns 2x..2x+2 and rows 2y..2y+2,
// clamped at the last column and row, divided by 16 with an arithmetic shift
// (rounds toward minus infinity). Output pixel x of row y is made from source
// pixel (2x+2, 2y+2), or from the last column/row of the source. Set
// out_width (1..512) and out_height (1..4096) through the config port between
// frames only. The block takes one source pixel per clock unless the input
// stalls: an accepted word is held in the filter stage, where its line-store
// read data arrives, and its reduced pixel is loaded into the output register
// as the word leaves that stage. The line store has one read and one write
// port, each used once per source pixel. The input stalls only while the
// filter stage holds a word that yields a pixel and the output register is
// full and not taken. tlast marks the last pixel of the reduced frame.
module rgba_pyramid_reduce_3x3_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Source pixels
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rpr_pkg::PixelBits-1:0]       s_axis_tdata,  // sample_c0..sample_c3
  // Reduced pixels
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rpr_pkg::OutDataBits-1:0]     m_axis_tdata,  // reduced_c0..c3, out_col, out_row
  output logic                                m_axis_tlast,  // frame_done
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rpr_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [rpr_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import rpr_pkg::*;

  scan_info_t  head_info;
  logic        in_acc;

  logic        s1_v_q;
  scan_info_t  s1_info_q;
  pixel_t      s1_pix_q;
  logic        s1_go;

  line_word_t  lines_rd;
  line_word_t  lines_wr;
  pixel_t      res;

  logic                    out_v_q, out_v_d;
  pixel_t                  out_pix_q;
  logic [OutColBits-1:0]   out_col_q;
  logic [OutRowBits-1:0]   out_row_q;
  logic                    out_last_q;

  assign cfg_ready_o = 1'b1;

  // Filter stage moves when its word yields nothing or the output has room
  assign s1_go         = s1_v_q && (!s1_info_q.emit || !out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  rpr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (in_acc),
    .info_o      (head_info)
  );

  // Line store: read on accept, write back when the word leaves the filter stage
  assign lines_wr.two_back = lines_rd.one_back;
  assign lines_wr.one_back = s1_pix_q;

  rpr_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (head_info.addr),
    .rd_data_o (lines_rd),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_info_q.addr),
    .wr_data_i (lines_wr)
  );

  rpr_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_go),
    .last_col_i (s1_info_q.last_col),
    .last_row_i (s1_info_q.last_row),
    .cur_i      (s1_pix_q),
    .lines_i    (lines_rd),
    .res_o      (res)
  );

  // Filter stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_info_q <= head_info;
      s1_pix_q  <= s_axis_tdata;
    end
  end

  // Output register
  always_comb begin
    out_v_d = out_v_q;
    if (m_axis_tready) out_v_d = 1'b0;
    if (s1_go && s1_info_q.emit) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_info_q.emit) begin
      out_pix_q  <= res;
      out_col_q  <= s1_info_q.out_col;
      out_row_q  <= s1_info_q.out_row;
      out_last_q <= s1_info_q.last_col && s1_info_q.last_row;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OutDataBits'({out_row_q, out_col_q, out_pix_q});
  assign m_axis_tlast  = out_last_q;

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_info_q.emit |=> m_axis_tvalid)
    else $error("emitted word did not reach the output register");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_info_q.emit && m_axis_tvalid && !m_axis_tready
    |=> s1_v_q && $stable(s1_info_q.addr))
    else $error("filter stage lost a word while output stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_info_q.emit && !s1_info_q.last_col |=> !m_axis_tlast)
    else $error("frame end flagged away from the last column");

endmodule

// ----- rtl/rpr_scan.sv -----
module rpr_scan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [rpr_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [rpr_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                advance_i,
  output rpr_pkg::scan_info_t                 info_o
);
  import rpr_pkg::*;

  logic [WidthRegBits-1:0]  width_q;
  logic [HeightRegBits-1:0] height_q;
  logic [ColBits-1:0]       col_q, col_d;
  logic [RowBits-1:0]       row_q, row_d;
  logic [WidthRegBits-1:0]  w_eff;
  logic [HeightRegBits-1:0] h_eff;
  logic [ColBits:0]         last_col_pos;
  logic [RowBits:0]         last_row_pos;
  logic [ColBits-1:0]       col_m2;
  logic [RowBits-1:0]       row_m2;
  logic [WidthRegBits-1:0]  w_m1;
  logic [HeightRegBits-1:0] h_m1;
  logic                     emit_col, emit_row;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegBits'(MaxOutWidth);
      height_q <= HeightRegBits'(512);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OUT_WIDTH:  width_q  <= cfg_data_i[WidthRegBits-1:0];
        CFG_OUT_HEIGHT: height_q <= cfg_data_i[HeightRegBits-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into their legal range
  always_comb begin
    if (width_q == '0) w_eff = WidthRegBits'(1);
    else if (width_q > WidthRegBits'(MaxOutWidth)) w_eff = WidthRegBits'(MaxOutWidth);
    else w_eff = width_q;
    if (height_q == '0) h_eff = HeightRegBits'(1);
    else if (height_q > HeightRegBits'(MaxOutHeight)) h_eff = HeightRegBits'(MaxOutHeight);
    else h_eff = height_q;
  end

  // Edge detection and output position
  always_comb begin
    last_col_pos = (ColBits+1)'({w_eff, 1'b0}) - (ColBits+1)'(1);
    last_row_pos = {h_eff, 1'b0} - (RowBits+1)'(1);
    col_m2       = col_q - ColBits'(2);
    row_m2       = row_q - RowBits'(2);
    w_m1         = w_eff - WidthRegBits'(1);
    h_m1         = h_eff - HeightRegBits'(1);

    info_o.last_col = {1'b0, col_q} >= last_col_pos;
    info_o.last_row = {1'b0, row_q} >= last_row_pos;
    emit_col = info_o.last_col || ((|col_q[ColBits-1:1]) && !col_q[0]);
    emit_row = info_o.last_row || ((|row_q[RowBits-1:1]) && !row_q[0]);
    info_o.emit = emit_col && emit_row;
    info_o.addr = col_q;
    info_o.out_col = info_o.last_col ? w_m1[OutColBits-1:0] : col_m2[OutColBits:1];
    info_o.out_row = info_o.last_row ? h_m1[OutRowBits-1:0] : row_m2[OutRowBits:1];
  end

  // Raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (info_o.last_col) begin
        col_d = '0;
        row_d = info_o.last_row ? '0 : row_q + RowBits'(1);
      end else begin
        col_d = col_q + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && info_o.last_col |=> col_q == '0)
    else $error("column did not wrap after last column");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !info_o.last_col |=> col_q == $past(col_q) + ColBits'(1))
    else $error("column did not step by one");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !info_o.last_col |=> $stable(row_q))
    else $error("row moved inside a source row");

endmodule

// ----- rtl/rpr_line_mem.sv -----
module rpr_line_mem (
  input  logic                              clk_i,
  input  logic                              rd_en_i,
  input  logic [rpr_pkg::AddrBits-1:0]      rd_addr_i,
  output rpr_pkg::line_word_t               rd_data_o,
  input  logic                              wr_en_i,
  input  logic [rpr_pkg::AddrBits-1:0]      wr_addr_i,
  input  rpr_pkg::line_word_t               wr_data_i
);
  import rpr_pkg::*;

  // Both earlier source rows, one word per source column
  line_word_t mem [MaxSrcWidth];
  line_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/rpr_filter.sv -----
module rpr_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 last_col_i,
  input  logic                 last_row_i,
  input  rpr_pkg::pixel_t      cur_i,
  input  rpr_pkg::line_word_t  lines_i,
  output rpr_pkg::pixel_t      res_o
);
  import rpr_pkg::*;

  // Vertical sums of the two earlier columns and of the current one, per channel
  logic signed [VsumBits-1:0] hold0_q [Channels];
  logic signed [VsumBits-1:0] hold1_q [Channels];
  logic signed [VsumBits-1:0] vsum    [Channels];

  for (genvar k = 0; k < Channels; k++) begin : g_ch
    logic signed [VsumBits-1:0] cur_x, a_x, b_x;
    logic signed [AccBits-1:0]  h0_x, h1_x, v_x, acc;

    // Vertical 1-2-1, or b + 3*cur on the last row
    always_comb begin
      cur_x = VsumBits'($signed(cur_i[k]));
      a_x   = VsumBits'($signed(lines_i.two_back[k]));
      b_x   = VsumBits'($signed(lines_i.one_back[k]));
      if (last_row_i) vsum[k] = b_x + (cur_x <<< 1) + cur_x;
      else            vsum[k] = a_x + (b_x <<< 1) + cur_x;
    end

    // Horizontal 1-2-1, or h1 + 3*v on the last column; floor divide by 16
    always_comb begin
      h0_x = AccBits'(hold0_q[k]);
      h1_x = AccBits'(hold1_q[k]);
      v_x  = AccBits'(vsum[k]);
      if (last_col_i) acc = h1_x + (v_x <<< 1) + v_x;
      else            acc = h0_x + (h1_x <<< 1) + v_x;
      res_o[k] = acc[AccBits-1:4];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hold0_q[k] <= '0;
        hold1_q[k] <= '0;
      end else if (step_i) begin
        hold0_q[k] <= hold1_q[k];
        hold1_q[k] <= vsum[k];
      end
    end
  end

endmodule

// ----- dv/tb_rgba_pyramid_reduce_3x3_core.sv -----
module tb_rgba_pyramid_reduce_3x3_core;
  import rpr_pkg::*;

  localparam int unsigned QuietLimit   = 2000;  // cycles with no handshake at all
  localparam int unsigned DrainPause   = 6;     // results trail their source word
  localparam int unsigned RandomItems  = 620;

  // Expected reduced pixel, one per emitting source word
  typedef struct packed {
    pixel_t                chan;
    logic [OutColBits-1:0] col;
    logic [OutRowBits-1:0] row;
    logic                  done;
  } reduced_px_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [PixelBits-1:0]       s_axis_tdata  = '0;  // sample_c0..sample_c3
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OutDataBits-1:0]     m_axis_tdata;        // reduced_c0..c3, out_col, out_row
  logic                       m_axis_tlast;        // frame_done
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxBits-1:0]      cfg_index_i   = CFG_OUT_WIDTH;
  logic [CfgDataBits-1:0]     cfg_data_i    = '0;

  rgba_pyramid_reduce_3x3_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Full-scale and bit-pattern sample values
  logic [SampleBits-1:0] corner_vals [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                             16'h0001, 16'hAAAA, 16'h5555, 16'h7FF0};

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_left = 0;
  int unsigned fault_count    = 0;
  int unsigned quiet_cycles   = 0;

  // Filter model state
  logic [WidthRegBits-1:0]  width_reg  = 10'd512;
  logic [HeightRegBits-1:0] height_reg = 13'd512;
  int                       line_two [Channels][MaxSrcWidth];
  int                       line_one [Channels][MaxSrcWidth];
  int                       col_hold [2][Channels];
  int unsigned              scan_col = 0;
  int unsigned              scan_row = 0;
  reduced_px_t              reduced_px_q [$];

  // Effective sizes after the zero and saturation rules
  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MaxOutWidth) w = MaxOutWidth;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MaxOutHeight) h = MaxOutHeight;
    return h;
  endfunction

  // 1-2-1 by 1-2-1 window update for one source word
  task automatic binomial_reduce(input pixel_t px);
    int unsigned w, h, c, r, ci;
    bit          last_col, last_row, emit_col, emit_row;
    int          cur, vsum, acc;
    reduced_px_t res;
    w  = eff_width();
    h  = eff_height();
    c  = scan_col;
    r  = scan_row;
    ci = (c < MaxSrcWidth) ? c : MaxSrcWidth - 1;
    last_col = c >= 2 * w - 1;
    last_row = r >= 2 * h - 1;
    emit_col = last_col || (c >= 2 && c[0] == 1'b0);
    emit_row = last_row || (r >= 2 && r[0] == 1'b0);
    res = '0;
    for (int k = 0; k < Channels; k++) begin
      cur  = $signed(px[k]);
      vsum = last_row ? line_one[k][ci] + 3 * cur
                      : line_two[k][ci] + 2 * line_one[k][ci] + cur;
      acc  = last_col ? col_hold[1][k] + 3 * vsum
                      : col_hold[0][k] + 2 * col_hold[1][k] + vsum;
      // floor divide by 16
      res.chan[k]       = 16'(acc >>> 4);
      line_two[k][ci]   = line_one[k][ci];
      line_one[k][ci]   = cur;
      col_hold[0][k]    = col_hold[1][k];
      col_hold[1][k]    = vsum;
    end
    if (last_col) begin
      scan_col = 0;
      scan_row = last_row ? 0 : (r + 1) & 32'h1FFF;
    end else begin
      scan_col = (c + 1) & 32'h3FF;
    end
    if (emit_col && emit_row) begin
      res.col  = OutColBits'(last_col ? w - 1 : (c - 2) >> 1);
      res.row  = OutRowBits'(last_row ? h - 1 : (r - 2) >> 1);
      res.done = last_col && last_row;
      reduced_px_q = {reduced_px_q, res};
    end
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    for (int k = 0; k < Channels; k++)
      px[k] = ($urandom_range(7) == 0) ? corner_vals[3'($urandom_range(7))] : 16'($urandom);
    return px;
  endfunction

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Offer one source word, with random gaps ahead of it
  task automatic push_pixel(input pixel_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    binomial_reduce(px);
    @(negedge clk_i);
  endtask

  // Stop sending and let every pending reduced pixel come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (reduced_px_q.size() != 0) @(negedge clk_i);
    repeat (DrainPause) @(negedge clk_i);
  endtask

  // Width and height writes, only with the block idle
  task automatic set_geometry(input logic [CfgDataBits-1:0] w_raw,
                              input logic [CfgDataBits-1:0] h_raw);
    logic [CfgIdxBits-1:0]  idx [2];
    logic [CfgDataBits-1:0] val [2];
    idx[0] = CFG_OUT_WIDTH;
    idx[1] = CFG_OUT_HEIGHT;
    val[0] = w_raw;
    val[1] = h_raw;
    wait_drained();
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (idx[i] == CFG_OUT_WIDTH) width_reg = val[i][WidthRegBits-1:0];
      else height_reg = val[i];
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic stream_frame(output int unsigned n_pix);
    n_pix = 4 * eff_width() * eff_height();
    for (int unsigned i = 0; i < n_pix; i++) push_pixel(random_pixel());
  endtask

  // Uniform full-scale frames, then a 4x4 source of mixed corner values
  task automatic test_directed_patterns();
    pixel_t px;
    set_idling(0, 0);
    set_geometry(13'd1, 13'd1);
    for (int i = 0; i < 4; i++) push_pixel({Channels{16'h8000}});
    for (int i = 0; i < 4; i++) push_pixel({Channels{16'h7FFF}});
    set_geometry(13'd2, 13'd2);
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < Channels; k++) px[k] = corner_vals[3'((i + 3 * k) % 8)];
      push_pixel(px);
    end
  endtask

  // Zero sizes and width bits above the register
  task automatic test_size_extremes();
    int unsigned n;
    set_idling(0, 0);
    set_geometry(13'd0, 13'd2);
    stream_frame(n);
    set_idling(27, 27);
    set_geometry(13'd3, 13'd0);
    stream_frame(n);
    set_idling(66, 0);
    set_geometry(13'h0C02, 13'd1);
    stream_frame(n);
    set_idling(0, 66);
    set_geometry(13'd0, 13'd0);
    stream_frame(n);
  endtask

  // Long output stall that backs up the input, then a mid-frame drain
  task automatic test_backpressure();
    set_idling(0, 0);
    set_geometry(13'd6, 13'd3);
    for (int i = 0; i < 72; i++) begin
      if (i == 8) sink_hold_left = 90;
      if (i == 40) wait_drained();
      push_pixel(random_pixel());
    end
  endtask

  // Random small frames, cycling through the idling phases
  task automatic test_random_frames();
    int unsigned sent, frame_no, n;
    logic [CfgDataBits-1:0] w_raw, h_raw;
    sent     = 0;
    frame_no = 0;
    while (sent < RandomItems) begin
      case (frame_no % 4)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(27, 27);
      endcase
      w_raw = ($urandom_range(5) == 0) ? CfgDataBits'($urandom_range(24, 9))
                                       : CfgDataBits'($urandom_range(8, 1));
      // bits above the width register are dropped by the block
      if ($urandom_range(3) == 0)
        w_raw[CfgDataBits-1:WidthRegBits] = 3'($urandom_range(7, 1));
      h_raw = CfgDataBits'($urandom_range(5, 1));
      set_geometry(w_raw, h_raw);
      stream_frame(n);
      sent += n;
      frame_no++;
    end
  endtask

  // Output side: random stalls plus an occasional long hold
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_left = sink_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Compare each output word with the oldest expected pixel
  always @(posedge clk_i) begin
    reduced_px_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reduced_px_q.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected word: expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = reduced_px_q.pop_front();
        for (int k = 0; k < Channels; k++)
          check_field($sformatf("reduced_c%0d", k), want.chan[k],
                      m_axis_tdata[k*SampleBits +: SampleBits]);
        check_field("out_col", 16'(want.col), 16'(m_axis_tdata[PixelBits +: OutColBits]));
        check_field("out_row", 16'(want.row),
                    16'(m_axis_tdata[PixelBits+OutColBits +: OutRowBits]));
        check_field("frame_done", 16'(want.done), 16'(m_axis_tlast));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("rgba_pyramid_reduce_3x3_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_patterns();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    wait_drained();
    if (fault_count == 0) begin
      $display("rgba_pyramid_reduce_3x3_core verification clean");
    end else begin
      $display("rgba_pyramid_reduce_3x3_core verification failed");
    end
    $finish;
  end

endmodule
